FILE: hdl/sfq_pkg.sv
package sfq_pkg;

  localparam int DEPTH    = 16;
  localparam int ID_BITS  = 8;
  localparam int KEY_BITS = 16;
  localparam int CNT_W    = $clog2(DEPTH + 1);

  // command codes
  localparam logic [2:0] CMD_APPEND   = 3'd0;
  localparam logic [2:0] CMD_SORTED   = 3'd1;
  localparam logic [2:0] CMD_DEQUEUE  = 3'd2;
  localparam logic [2:0] CMD_REMOVE   = 3'd3;
  localparam logic [2:0] CMD_CONTAINS = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [2:0]          cmd;
    logic [ID_BITS-1:0]  node_id;
    logic [KEY_BITS-1:0] node_key;
  } sfq_req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [ID_BITS-1:0]  out_id;
    logic [KEY_BITS-1:0] out_key;
    logic                found;
  } sfq_rsp_t;

  typedef struct packed {
    logic [ID_BITS-1:0]  id;
    logic [KEY_BITS-1:0] key;
  } sfq_entry_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic       insert;     // open a slot (else close one)
    logic       match_key;  // sorted insert: stop at first larger key
    logic       match_id;   // remove / contains: stop at first equal id
    logic       apply;      // commit the shift this cycle
    sfq_entry_t item;       // entry carried by the command
  } sfq_ctrl_t;

endpackage

FILE: hdl/sfq_cell.sv
module sfq_cell import sfq_pkg::*; (
  input  logic       clk,
  input  sfq_ctrl_t  ctrl,
  input  logic       valid,
  input  sfq_entry_t left,
  input  sfq_entry_t right,
  input  logic       chain_in,
  output logic       chain_out,
  output sfq_entry_t entry
);

  logic       hit;
  sfq_entry_t entry_next;

  // local match; chain_in says a cell nearer the head already matched
  always_comb begin
    if (ctrl.insert) begin
      hit = !valid || (ctrl.match_key && (entry.key > ctrl.item.key));
    end else begin
      hit = valid && (!ctrl.match_id || (entry.id == ctrl.item.id));
    end
  end

  assign chain_out = chain_in | hit;

  always_comb begin
    entry_next = entry;
    if (ctrl.apply) begin
      if (ctrl.insert) begin
        if (chain_in) begin
          entry_next = left;        // shift toward the tail
        end else if (hit) begin
          entry_next = ctrl.item;   // the new entry lands here
        end
      end else if (chain_out) begin
        entry_next = right;         // close the gap toward the head
      end
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

FILE: hdl/sorted_fifo_queue_engine_unit.sv
// Sorted queue of up to DEPTH (id, key) entries in a row of cells, head at cell 0.
//
// Command channel: present req and raise start; the beat is taken at a rising
// edge with start high and busy low. Commands are append at tail, sorted
// insert (after every entry with key less than or equal), dequeue head,
// remove first matching id, and contains.
//
// Result channel: every command yields exactly one result beat on rsp, marked
// by done for one cycle. The receiver cannot stall, so there is no hold-off.
//
// Timing: the command is registered at acceptance, then an execute cycle in
// which every cell compares against the broadcast command and a match bit
// ripples from head to tail through the cells; at the end of that cycle all
// cells shift together and the result is registered. done is high in the
// cycle after that. busy is high during the execute cycle only, so a new
// command is not taken until the previous one has left the execute cycle.
//
// Reset (rst, synchronous, active high) empties the queue and drops any
// result in flight; cell contents are not cleared, as only entries below the
// fill count are ever read.
module sorted_fifo_queue_engine_unit import sfq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  sfq_req_t req,
  output logic     busy,
  output logic     done,
  output sfq_rsp_t rsp
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t           state;
  sfq_req_t         cmd_q;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  sfq_rsp_t         rsp_next;

  sfq_ctrl_t  ctrl;
  sfq_entry_t cell_entry [DEPTH];
  logic       chain [DEPTH+1];
  logic       cell_valid [DEPTH];

  logic is_insert;
  logic is_remove;
  logic full;
  logic empty;
  logic found_any;

  assign busy = (state == S_EXEC);

  assign is_insert = (cmd_q.cmd == CMD_APPEND) || (cmd_q.cmd == CMD_SORTED);
  assign is_remove = (cmd_q.cmd == CMD_DEQUEUE) || (cmd_q.cmd == CMD_REMOVE);
  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign found_any = chain[DEPTH];

  // broadcast the command; apply only in the execute cycle
  always_comb begin
    ctrl.insert    = is_insert;
    ctrl.match_key = (cmd_q.cmd == CMD_SORTED);
    ctrl.match_id  = (cmd_q.cmd == CMD_REMOVE) || (cmd_q.cmd == CMD_CONTAINS);
    ctrl.item.id   = cmd_q.node_id;
    ctrl.item.key  = cmd_q.node_key;
    ctrl.apply     = busy && ((is_insert && !full) ||
                              (is_remove && !empty && found_any));
  end

  assign chain[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sfq_entry_t left_n;
    sfq_entry_t right_n;

    assign cell_valid[i] = (CNT_W'(i) < count);

    if (i == 0) begin : g_head
      assign left_n = ctrl.item;
    end else begin : g_mid
      assign left_n = cell_entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_n = cell_entry[i];
    end else begin : g_body
      assign right_n = cell_entry[i+1];
    end

    sfq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .valid     (cell_valid[i]),
      .left      (left_n),
      .right     (right_n),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1]),
      .entry     (cell_entry[i])
    );
  end

  // result and fill count for the command in execution
  always_comb begin
    rsp_next   = '0;
    count_next = count;
    case (cmd_q.cmd)
      CMD_APPEND, CMD_SORTED: begin
        if (full) begin
          rsp_next.status = ST_FULL;
        end else begin
          count_next = count + 1'b1;
        end
      end
      CMD_DEQUEUE: begin
        if (empty) begin
          rsp_next.status = ST_EMPTY;
        end else begin
          rsp_next.out_id  = cell_entry[0].id;
          rsp_next.out_key = cell_entry[0].key;
          count_next       = count - 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (empty) begin
          rsp_next.status = ST_EMPTY;
        end else if (!found_any) begin
          rsp_next.status = ST_NOT_FOUND;
        end else begin
          count_next = count - 1'b1;
        end
      end
      CMD_CONTAINS: begin
        if (empty) begin
          rsp_next.status = ST_EMPTY;
        end else begin
          rsp_next.found = found_any;
        end
      end
      default: begin
        // unused codes: drop the command, report ok with zero fields
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          // each beat passes through the execute state; the next beat is taken from idle
          count <= count_next;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload: hold the command and the result beat
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_q <= req;
    end
    if (busy) begin
      rsp <= rsp_next;
    end
  end

  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result beat without an execute cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("fill count beyond depth");

  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    done && (rsp.status == ST_FULL) |-> full)
    else $error("full reported but queue changed");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(busy) && !$past(rst) |-> $stable(count))
    else $error("fill count moved outside execute cycle");

endmodule
